### design/wzs_pkg.sv
`default_nettype none

package wzs_pkg;

  // Default sizing of the stack.
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  // Value of the window limit register after reset.
  localparam logic [4:0] MAXW_RESET = 5'd16;

  // Action codes.
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_FOCUS  = 3'd2;
  localparam logic [2:0] ACT_CYCLE  = 3'd3;
  localparam logic [2:0] ACT_FIND   = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_MISS    = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] window_id;
  } wzs_request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [7:0] affected_id;
    logic [7:0] top_id;
    logic [7:0] bottom_id;
    logic [4:0] count;
  } wzs_result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_CYC_GET,
    S_MOVE,
    S_FINAL,
    S_TOP_RD,
    S_BOT_RD,
    S_REPORT
  } state_t;

  // Source of the affected id in the result.
  typedef enum logic [1:0] {
    AFF_ID,
    AFF_ZERO,
    AFF_RDATA
  } aff_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       search_init;
    logic       search_step;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_use_hit;
    aff_sel_t   aff_sel;
    logic       cyc_rd;
    logic       cyc_get;
    logic       move_init;
    logic       move_step;
    logic       final_wr;
    logic       top_rd;
    logic       bot_rd;
    logic       report;
  } wzs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] act;
    logic       full;
    logic       ge2;
    logic       hit;
    logic       miss;
    logic       move_done;
  } wzs_stat_t;

endpackage

`default_nettype wire

### design/wzs_ram.sv
`default_nettype none

module wzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/wzs_ctrl.sv
`default_nettype none

module wzs_ctrl import wzs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire wzs_stat_t stat,
  output logic           busy,
  output wzs_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    cmd.aff_sel = AFF_ID;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          ACT_ADD: begin
            if (stat.full) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_TOP_RD;
            end else begin
              cmd.search_init = 1'b1;
              state_next      = S_SEARCH;
            end
          end
          ACT_REMOVE, ACT_FOCUS, ACT_FIND: begin
            cmd.search_init = 1'b1;
            state_next      = S_SEARCH;
          end
          ACT_CYCLE: begin
            if (stat.ge2) begin
              cmd.cyc_rd = 1'b1;
              state_next = S_CYC_GET;
            end else begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISS;
              cmd.aff_sel    = AFF_ZERO;
              state_next     = S_TOP_RD;
            end
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_MISS;
            state_next     = S_TOP_RD;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.hit) begin
          cmd.set_res     = 1'b1;
          cmd.res_use_hit = 1'b1;
          unique case (stat.act)
            ACT_ADD: begin
              cmd.res_status = ST_PRESENT;
              state_next     = S_TOP_RD;
            end
            ACT_REMOVE, ACT_FOCUS: begin
              cmd.res_status = ST_OK;
              cmd.move_init  = 1'b1;
              state_next     = S_MOVE;
            end
            default: begin
              cmd.res_status = ST_OK;
              state_next     = S_TOP_RD;
            end
          endcase
        end else if (stat.miss) begin
          cmd.set_res = 1'b1;
          if (stat.act == ACT_ADD) begin
            cmd.res_status = ST_OK;
            cmd.move_init  = 1'b1;
            state_next     = S_MOVE;
          end else begin
            cmd.res_status = ST_MISS;
            state_next     = S_TOP_RD;
          end
        end
      end
      S_CYC_GET: begin
        cmd.cyc_get    = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.aff_sel    = AFF_RDATA;
        cmd.move_init  = 1'b1;
        state_next     = S_MOVE;
      end
      S_MOVE: begin
        cmd.move_step = 1'b1;
        if (stat.move_done) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_wr = 1'b1;
        state_next   = S_TOP_RD;
      end
      S_TOP_RD: begin
        cmd.top_rd = 1'b1;
        state_next = S_BOT_RD;
      end
      S_BOT_RD: begin
        cmd.bot_rd = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/wzs_datapath.sv
`default_nettype none

module wzs_datapath import wzs_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire wzs_cmd_t     cmd,
  input  wire wzs_request_t request,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_data,
  output wzs_stat_t         stat,
  output logic              done,
  output wzs_result_t       result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  function automatic logic [7:0] to8(input logic [ID_BITS-1:0] v);
    logic [ID_BITS+7:0] e;
    e = {8'b0, v};
    return e[7:0];
  endfunction

  function automatic logic [3:0] to4(input logic [IW-1:0] v);
    logic [IW+3:0] e;
    e = {4'b0, v};
    return e[3:0];
  endfunction

  // Latched request and configuration.
  logic [2:0]         act;
  logic [ID_BITS-1:0] id;
  logic [4:0]         max_windows;
  logic [CW-1:0]      count;

  // Search walk.
  logic [CW-1:0] scan;
  logic          spend;
  logic [IW-1:0] sidx;

  // Shift walk.
  logic          down;
  logic [IW-1:0] src;
  logic [CW-1:0] remaining;
  logic          mpend;
  logic [IW-1:0] mdst;

  // Result fields collected along the way.
  logic [ID_BITS-1:0] cyc_top;
  logic [ID_BITS-1:0] top_q;
  logic [1:0]         res_status;
  logic [IW-1:0]      res_pos;
  logic [7:0]         res_aff;

  // Memory port signals.
  logic               we;
  logic [IW-1:0]      waddr;
  logic [ID_BITS-1:0] wdata;
  logic [IW-1:0]      raddr;
  logic [ID_BITS-1:0] rdata;

  logic [ID_BITS+7:0] id_ext;
  logic [CW-1:0]      cm1;
  logic [4+CW:0]      cnt_ext;
  logic               search_can;

  assign id_ext     = {{ID_BITS{1'b0}}, request.window_id};
  assign cm1        = count - CW'(1);
  assign cnt_ext    = {5'b0, count};
  assign search_can = (scan < count);

  // Status toward the controller.
  always_comb begin
    stat.act       = act;
    stat.full      = (LW'(count) >= LW'(max_windows)) || (count >= CW'(DEPTH));
    stat.ge2       = (count >= CW'(2));
    stat.hit       = spend && (rdata == id);
    stat.miss      = !spend && !search_can;
    stat.move_done = (remaining == '0) && !mpend;
  end

  // Read address selection.
  always_comb begin
    raddr = '0;
    if (cmd.search_step) begin
      raddr = scan[IW-1:0];
    end else if (cmd.move_step) begin
      raddr = src;
    end else if (cmd.bot_rd) begin
      raddr = cm1[IW-1:0];
    end else if (cmd.cyc_rd || cmd.top_rd) begin
      raddr = '0;
    end
  end

  // Write port: shifted entries during the walk, then the final placement.
  always_comb begin
    we    = 1'b0;
    waddr = mdst;
    wdata = rdata;
    if (cmd.move_step && mpend) begin
      we = 1'b1;
    end else if (cmd.final_wr) begin
      unique case (act)
        ACT_ADD, ACT_FOCUS: begin
          we    = 1'b1;
          waddr = '0;
          wdata = id;
        end
        ACT_CYCLE: begin
          we    = 1'b1;
          waddr = cm1[IW-1:0];
          wdata = cyc_top;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  wzs_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_windows <= MAXW_RESET;
      count       <= '0;
      spend       <= 1'b0;
      mpend       <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_windows <= cfg_data;
      end
      if (cmd.final_wr) begin
        if (act == ACT_ADD) begin
          count <= count + CW'(1);
        end else if (act == ACT_REMOVE) begin
          count <= cm1;
        end
      end
      if (cmd.search_init) begin
        spend <= 1'b0;
      end else if (cmd.search_step) begin
        spend <= search_can;
      end
      if (cmd.move_init) begin
        mpend <= 1'b0;
      end else if (cmd.move_step) begin
        mpend <= (remaining != '0);
      end
      done <= cmd.report;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= request.action;
      id  <= id_ext[ID_BITS-1:0];
    end

    // Search walk: issue one read per cycle, compare the read data in the next cycle.
    if (cmd.search_init) begin
      scan <= '0;
    end else if (cmd.search_step && search_can) begin
      scan <= scan + CW'(1);
      sidx <= scan[IW-1:0];
    end

    // Shift walk setup depends on the operation.
    if (cmd.move_init) begin
      unique case (act)
        ACT_ADD: begin
          down      <= 1'b1;
          src       <= cm1[IW-1:0];
          remaining <= count;
        end
        ACT_FOCUS: begin
          down      <= 1'b1;
          src       <= sidx - IW'(1);
          remaining <= CW'(sidx);
        end
        ACT_REMOVE: begin
          down      <= 1'b0;
          src       <= sidx + IW'(1);
          remaining <= count - CW'(sidx) - CW'(1);
        end
        default: begin
          down      <= 1'b0;
          src       <= IW'(1);
          remaining <= cm1;
        end
      endcase
    end else if (cmd.move_step && (remaining != '0)) begin
      mdst      <= down ? (src + IW'(1)) : (src - IW'(1));
      src       <= down ? (src - IW'(1)) : (src + IW'(1));
      remaining <= remaining - CW'(1);
    end

    if (cmd.cyc_get) begin
      cyc_top <= rdata;
    end

    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_pos    <= cmd.res_use_hit ? sidx : '0;
      case (cmd.aff_sel)
        AFF_ZERO:  res_aff <= 8'd0;
        AFF_RDATA: res_aff <= to8(rdata);
        default:   res_aff <= to8(id);
      endcase
    end

    if (cmd.bot_rd) begin
      top_q <= rdata;
    end

    // Result register: the bottom entry arrives from the read issued last cycle.
    if (cmd.report) begin
      result.status      <= res_status;
      result.position    <= to4(res_pos);
      result.affected_id <= res_aff;
      result.top_id      <= (count != '0) ? to8(top_q) : 8'd0;
      result.bottom_id   <= (count != '0) ? to8(rdata) : 8'd0;
      result.count       <= cnt_ext[4:0];
    end
  end

endmodule

`default_nettype wire

### design/window_z_order_stack_unit.sv
// Channel   Direction  Signals                   Transfer when
// request   in         start, busy, request      start high and busy low
// result    out        done, result              done high, one cycle, no stall
// config    in         cfg_we, cfg_data          cfg_we high
//
// A rejected operation (full add, short cycle, undefined action) goes straight
// to the report; a find or a failed lookup walks the stack, and add, remove,
// focus and cycle also shift the entries.
// Both walks are bounded by the single read port of the order memory: the lookup
// and the shift each visit one entry per cycle.
// Synchronous reset empties the stack and sets the window limit to 16.
// The result is shown for one cycle and cannot be held off by the receiver.
`default_nettype none

module window_z_order_stack_unit import wzs_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire wzs_request_t request,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_data,
  output logic              done,
  output wzs_result_t       result
);

  wzs_cmd_t  cmd;
  wzs_stat_t stat;

  wzs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  wzs_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stat     (stat),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

### design/wzs_checker.sv
`default_nettype none

module wzs_checker import wzs_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire wzs_result_t result
);

  // An accepted transfer makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transfer");

  // A result only follows a cycle in which the block was busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding operation");

  // One result per operation: the strobe is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // An empty stack reports zero top and bottom ids.
  a_empty_ids: assert property (@(posedge clk) disable iff (rst)
    (done && (result.count == 5'd0)) |-> ((result.top_id == 8'd0) &&
                                          (result.bottom_id == 8'd0)))
    else $error("nonzero top or bottom id on an empty stack");

  // A rejected add on a full stack reports position zero.
  a_full_position: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_FULL)) |-> (result.position == 4'd0))
    else $error("full status with nonzero position");

endmodule

bind window_z_order_stack_unit wzs_checker u_wzs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
